FILE: hw/rtl/tdd_pattern_timing_steps_top_assert.svh
// ----------------------------------------------------------------------------
// tdd pattern timing steps assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef TDD_PATTERN_TIMING_STEPS_TOP_ASSERT_SVH
`define TDD_PATTERN_TIMING_STEPS_TOP_ASSERT_SVH

// same-cycle implication
`define TPTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TPTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/tdd_pts_pkg.sv
// ----------------------------------------------------------------------------
// tdd pattern timing steps package
// shared types, constants and the symbol duration table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdd_pts_pkg;

   // default module parameters
   localparam int SYMS_PER_SLOT_DEF  = 14;
   localparam int GAP_TICK_SCALE_DEF = 1;

   // field widths
   localparam int DUR_W  = 26;
   localparam int TICK_W = 15;

   // register indexes
   localparam logic [1:0] CSR_SCS_INDEX       = 2'd0;
   localparam logic [1:0] CSR_LONG_SYM_PERIOD = 2'd1;
   localparam logic [1:0] CSR_LISTEN_EN       = 2'd2;
   localparam logic [1:0] CSR_GAP_NS          = 2'd3;

   // step mode bits
   localparam logic [1:0] MODE_RX = 2'b01;
   localparam logic [1:0] MODE_TX = 2'b10;

   // subcarrier spacing codes
   localparam logic [2:0] SCS_15K  = 3'd0;
   localparam logic [2:0] SCS_30K  = 3'd1;
   localparam logic [2:0] SCS_60K  = 3'd2;
   localparam logic [2:0] SCS_120K = 3'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN_TX,
      ST_RUN_GUARD,
      ST_RUN_RX,
      ST_OUT_TX,
      ST_OUT_GUARD,
      ST_OUT_RX,
      ST_OUT_GAP
   } state_type;

   // sequencer to accumulator control
   typedef struct packed {
      logic clear_phase;
      logic clear_total;
      logic add;
   } acc_ctl_type;

   // sequencer to output register
   typedef struct packed {
      logic             load;
      logic [1:0]       mode;
      logic [DUR_W-1:0] duration;
      logic             last;
   } out_item_type;

   // symbol duration in ticks; undefined spacings act as 240 khz
   function automatic logic [TICK_W-1:0] sym_ticks(input logic [2:0] scs,
                                                   input logic       long_sym);
      logic [TICK_W-1:0] ticks;
      case (scs)
         SCS_15K:  ticks = long_sym ? 15'd17664 : 15'd17536;
         SCS_30K:  ticks = long_sym ? 15'd8896  : 15'd8768;
         SCS_60K:  ticks = long_sym ? 15'd4512  : 15'd4384;
         SCS_120K: ticks = long_sym ? 15'd2320  : 15'd2192;
         default:  ticks = long_sym ? 15'd1224  : 15'd1096;
      endcase
      return ticks;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tdd_pts_symacc.sv
// ----------------------------------------------------------------------------
// tdd pattern symbol accumulator
// shared adder: one symbol duration per cycle while add is set; tracks phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdd_pts_symacc
   import tdd_pts_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire acc_ctl_type      ctl,
   input  wire logic [2:0]       scs_index,
   input  wire logic [7:0]       long_sym_period,
   output logic      [DUR_W-1:0] total
);

   logic [7:0]       phase_ff, phase_in;
   logic [DUR_W-1:0] total_ff, total_in;
   logic [7:0]       period;
   logic [8:0]       phase_inc;
   logic [TICK_W-1:0] ticks;

   // zero period acts as one
   assign period    = (long_sym_period == 8'd0) ? 8'd1 : long_sym_period;
   assign phase_inc = {1'b0, phase_ff} + 9'd1;
   assign ticks     = sym_ticks(scs_index, phase_ff == 8'd0);

   // phase and running sum
   always_comb begin
      phase_in = phase_ff;
      total_in = total_ff;
      if (ctl.clear_phase) begin
         phase_in = 8'd0;
      end else if (ctl.add) begin
         phase_in = (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];
      end
      if (ctl.clear_total) begin
         total_in = '0;
      end else if (ctl.add) begin
         total_in = total_ff + DUR_W'(ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
      end
      total_ff <= total_in;
   end

   assign total = total_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tdd_pts_seq.sv
// ----------------------------------------------------------------------------
// tdd pattern sequencer
// counts symbols through the accumulator and emits the timing steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdd_pts_seq
   import tdd_pts_pkg::*;
#(
   parameter int SYMS_PER_SLOT  = SYMS_PER_SLOT_DEF,
   parameter int GAP_TICK_SCALE = GAP_TICK_SCALE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic             restart,
   input  wire logic [7:0]       dl_slot_count,
   input  wire logic [3:0]       dl_extra_syms,
   input  wire logic [7:0]       ul_slot_count,
   input  wire logic [3:0]       ul_extra_syms,
   input  wire logic             listen_en,
   input  wire logic [7:0]       gap_ns,
   input  wire logic [DUR_W-1:0] total,
   input  wire logic             out_free,
   output acc_ctl_type           acc_ctl,
   output out_item_type          out_item
);

   localparam int SYM_CNT_W  = $clog2(255 * SYMS_PER_SLOT + 16);
   localparam int GAP_PROD_W = 8 + $clog2(GAP_TICK_SCALE + 1);

   state_type state_ff, state_in;

   logic [SYM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SYM_CNT_W-1:0] g_cnt_ff, g_cnt_in;
   logic [SYM_CNT_W-1:0] ul_cnt_ff, ul_cnt_in;
   logic [DUR_W-1:0]     d_tx_ff, d_tx_in;
   logic [DUR_W-1:0]     d_idle_ff, d_idle_in;
   logic [DUR_W-1:0]     d_rx_ff, d_rx_in;

   logic                 accept;
   logic [SYM_CNT_W-1:0] dl_syms, ul_syms, g_syms;
   logic [4:0]           used;
   logic [GAP_PROD_W-1:0] gap_prod;
   logic [DUR_W-1:0]     gap_ticks, d_gap, idle_eff;
   logic                 e_tx, e_idle, e_rx, e_gap;
   logic                 cnt_zero;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;
   assign cnt_zero = (cnt_ff == '0);

   // symbol counts of the incoming pattern
   assign dl_syms = SYM_CNT_W'(dl_slot_count) * SYM_CNT_W'(SYMS_PER_SLOT)
                  + SYM_CNT_W'(dl_extra_syms);
   assign ul_syms = SYM_CNT_W'(ul_slot_count) * SYM_CNT_W'(SYMS_PER_SLOT)
                  + SYM_CNT_W'(ul_extra_syms);
   assign used    = {1'b0, dl_extra_syms} + {1'b0, ul_extra_syms};

   // guard only between downlink and uplink, clamped at a full slot
   always_comb begin
      g_syms = '0;
      if (dl_syms != '0 && ul_syms != '0 && used < 5'(SYMS_PER_SLOT)) begin
         g_syms = SYM_CNT_W'(SYMS_PER_SLOT) - SYM_CNT_W'(used);
      end
   end

   // gap in ticks and the guard it is taken from
   assign gap_prod  = GAP_PROD_W'(gap_ns) * GAP_PROD_W'(GAP_TICK_SCALE);
   assign gap_ticks = DUR_W'(gap_prod >> 2);
   assign d_gap     = (d_tx_ff != '0 && d_rx_ff != '0) ? gap_ticks : '0;
   assign idle_eff  = (d_idle_ff > d_gap) ? (d_idle_ff - d_gap) : d_idle_ff;

   // which steps are emitted
   assign e_tx   = (d_tx_ff != '0);
   assign e_idle = (idle_eff != '0);
   assign e_rx   = (d_rx_ff != '0);
   assign e_gap  = (d_gap != '0) && e_idle;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept) state_in = ST_RUN_TX;
         ST_RUN_TX:    if (cnt_zero) state_in = ST_RUN_GUARD;
         ST_RUN_GUARD: if (cnt_zero) state_in = ST_RUN_RX;
         ST_RUN_RX:    if (cnt_zero) state_in = ST_OUT_TX;
         ST_OUT_TX:    if (!e_tx || out_free) state_in = ST_OUT_GUARD;
         ST_OUT_GUARD: if (!e_idle || out_free) state_in = ST_OUT_RX;
         ST_OUT_RX:    if (!e_rx || out_free) state_in = ST_OUT_GAP;
         ST_OUT_GAP:   if (!e_gap || out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      acc_ctl   = '0;
      out_item  = '0;
      cnt_in    = cnt_ff;
      g_cnt_in  = g_cnt_ff;
      ul_cnt_in = ul_cnt_ff;
      d_tx_in   = d_tx_ff;
      d_idle_in = d_idle_ff;
      d_rx_in   = d_rx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               acc_ctl.clear_phase = restart;
               acc_ctl.clear_total = 1'b1;
               cnt_in    = dl_syms;
               g_cnt_in  = g_syms;
               ul_cnt_in = ul_syms;
            end
         end
         ST_RUN_TX: begin
            if (cnt_zero) begin
               d_tx_in = total;
               acc_ctl.clear_total = 1'b1;
               cnt_in = g_cnt_ff;
            end else begin
               acc_ctl.add = 1'b1;
               cnt_in = cnt_ff - SYM_CNT_W'(1);
            end
         end
         ST_RUN_GUARD: begin
            if (cnt_zero) begin
               d_idle_in = total;
               acc_ctl.clear_total = 1'b1;
               cnt_in = ul_cnt_ff;
            end else begin
               acc_ctl.add = 1'b1;
               cnt_in = cnt_ff - SYM_CNT_W'(1);
            end
         end
         ST_RUN_RX: begin
            if (cnt_zero) begin
               d_rx_in = total;
            end else begin
               acc_ctl.add = 1'b1;
               cnt_in = cnt_ff - SYM_CNT_W'(1);
            end
         end
         ST_OUT_TX: begin
            out_item.load     = e_tx && out_free;
            out_item.mode     = MODE_TX | {1'b0, listen_en};
            out_item.duration = d_tx_ff;
            out_item.last     = !(e_idle || e_rx || e_gap);
         end
         ST_OUT_GUARD: begin
            out_item.load     = e_idle && out_free;
            out_item.mode     = {1'b0, listen_en};
            out_item.duration = idle_eff;
            out_item.last     = !(e_rx || e_gap);
         end
         ST_OUT_RX: begin
            out_item.load     = e_rx && out_free;
            out_item.mode     = MODE_RX;
            out_item.duration = d_rx_ff;
            out_item.last     = !e_gap;
         end
         ST_OUT_GAP: begin
            out_item.load     = e_gap && out_free;
            out_item.mode     = {1'b0, listen_en};
            out_item.duration = d_gap;
            out_item.last     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      g_cnt_ff  <= g_cnt_in;
      ul_cnt_ff <= ul_cnt_in;
      d_tx_ff   <= d_tx_in;
      d_idle_ff <= d_idle_in;
      d_rx_ff   <= d_rx_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tdd_pattern_timing_steps_top.sv
// ----------------------------------------------------------------------------
// tdd pattern timing steps
// turns one tdd pattern into transmit, guard, receive and gap timing steps
// ----------------------------------------------------------------------------
// usage:
//   req_ channel takes one pattern item: slot counts and extra symbols in
//   req_tdata, the restart flag in req_tuser.
//   rsp_ channel gives up to four step items per pattern, in the order
//   transmit, guard, receive, gap; rsp_tlast marks the last one. steps of
//   zero duration are dropped, an empty pattern gives no item at all.
//   csr_ port writes scs_index, long_sym_period, the listen enable and gap_ns;
//   the user writes them only while the block is idle, the block does not enforce it.
//   timing: one symbol is added per cycle by a single accumulator while the
//   pattern is counted through its dl, guard and ul symbols; the next pattern
//   is taken once the last step has been loaded into the output register.
//   reset clears the symbol phase, the sequencer and the output valid flag and
//   loads the register defaults (scs 30 khz, period 14, listen off, gap 0).
//   a stalled receiver holds the step in the output register and the
//   sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdd_pattern_timing_steps_top
   import tdd_pts_pkg::*;
#(
   parameter int SYMS_PER_SLOT  = SYMS_PER_SLOT_DEF,
   parameter int GAP_TICK_SCALE = GAP_TICK_SCALE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // dl_slot_count[7:0], dl_extra_syms[11:8], ul_slot_count[19:12],
   // ul_extra_syms[23:20]
   input  wire logic [23:0] req_tdata,
   // restart[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // step_mode[1:0], step_duration[27:2], zero fill[31:28]
   output logic      [31:0] rsp_tdata,
   // step_last
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [2:0] scs_index_ff;
   logic [7:0] long_sym_period_ff;
   logic       listen_en_ff;
   logic [7:0] gap_ns_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_mode_ff;
   logic [DUR_W-1:0] rsp_dur_ff;
   logic             rsp_last_ff;

   acc_ctl_type      acc_ctl;
   out_item_type     out_item;
   logic [DUR_W-1:0] total;
   logic             out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scs_index_ff       <= SCS_30K;
         long_sym_period_ff <= 8'd14;
         listen_en_ff       <= 1'b0;
         gap_ns_ff          <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCS_INDEX:       scs_index_ff       <= csr_wdata[2:0];
            CSR_LONG_SYM_PERIOD: long_sym_period_ff <= csr_wdata;
            CSR_LISTEN_EN:       listen_en_ff       <= csr_wdata[0];
            CSR_GAP_NS:          gap_ns_ff          <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tdd_pts_symacc u_symacc (
      .clock           (clock),
      .reset           (reset),
      .ctl             (acc_ctl),
      .scs_index       (scs_index_ff),
      .long_sym_period (long_sym_period_ff),
      .total           (total)
   );

   tdd_pts_seq #(
      .SYMS_PER_SLOT  (SYMS_PER_SLOT),
      .GAP_TICK_SCALE (GAP_TICK_SCALE)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .restart       (req_tuser[0]),
      .dl_slot_count (req_tdata[7:0]),
      .dl_extra_syms (req_tdata[11:8]),
      .ul_slot_count (req_tdata[19:12]),
      .ul_extra_syms (req_tdata[23:20]),
      .listen_en     (listen_en_ff),
      .gap_ns        (gap_ns_ff),
      .total         (total),
      .out_free      (out_free),
      .acc_ctl       (acc_ctl),
      .out_item      (out_item)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_item.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_item.load) begin
         rsp_mode_ff <= out_item.mode;
         rsp_dur_ff  <= out_item.duration;
         rsp_last_ff <= out_item.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_dur_ff, rsp_mode_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tdd_pts_checker.sv
// ----------------------------------------------------------------------------
// tdd pattern timing steps checker
// port-level assertions, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tdd_pattern_timing_steps_top_assert.svh"

module tdd_pts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled step holds
   `TPTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // a pattern keeps the block busy for at least the next cycle
   `TPTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // zero-duration steps are never sent
   `TPTS_ASSERT_IMPLY(a_no_zero_step, clock, reset, rsp_tvalid, rsp_tdata[27:2] != 26'd0)

   // fill bits above the duration stay clear
   `TPTS_ASSERT_IMPLY(a_fill_zero, clock, reset, rsp_tvalid, rsp_tdata[31:28] == 4'd0)

endmodule

bind tdd_pattern_timing_steps_top tdd_pts_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
